/* rtl/dpf_pkg.sv */
// Shared types and constants for the damper position feedback block.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none
package dpf_pkg;

	localparam int RawW = 16;
	localparam int PosW = 14;
	localparam int QuietW = 4;
	localparam int ProdW = 30;
	localparam int DivSteps = PosW;
	localparam int StepW = $clog2(DivSteps);

	localparam logic [QuietW-1:0] QuietLimit = QuietW'(8);
	localparam logic [PosW-1:0] FullScale = PosW'(10000);

	typedef enum logic [2:0] {
		RegCalLow = 3'd0,
		RegCalHigh = 3'd1,
		RegLowMeansOpen = 3'd2,
		RegTargetIsOpen = 3'd3,
		RegSignalFloor = 3'd4,
		RegMinSpan = 3'd5,
		RegClosedLimit = 3'd6,
		RegMoveTolerance = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [RawW-1:0] cal_low;
		logic [RawW-1:0] cal_high;
		logic low_means_open;
		logic target_is_open;
		logic [RawW-1:0] signal_floor;
		logic [RawW-1:0] min_span;
		logic [PosW-1:0] closed_limit;
		logic [PosW-1:0] move_tolerance;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic init;
		logic step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_status_t;

endpackage
`default_nettype wire

/* rtl/dpf_cfg.sv */
// Configuration register file of the damper position feedback block.
// Depends on dpf_pkg for the register index codes and the cfg_t bundle.
`default_nettype none
module dpf_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [dpf_pkg::RawW-1:0] cfg_wdata,
	output dpf_pkg::cfg_t cfg
);

	dpf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_low <= '0;
			cfg_q.cal_high <= 16'hFFFF;
			cfg_q.low_means_open <= 1'b0;
			cfg_q.target_is_open <= 1'b0;
			cfg_q.signal_floor <= 16'd100;
			cfg_q.min_span <= 16'd100;
			cfg_q.closed_limit <= 14'd500;
			cfg_q.move_tolerance <= 14'd500;
		end else if (cfg_we) begin
			case (dpf_pkg::cfg_reg_t'(cfg_index))
				dpf_pkg::RegCalLow: cfg_q.cal_low <= cfg_wdata;
				dpf_pkg::RegCalHigh: cfg_q.cal_high <= cfg_wdata;
				dpf_pkg::RegLowMeansOpen: cfg_q.low_means_open <= cfg_wdata[0];
				dpf_pkg::RegTargetIsOpen: cfg_q.target_is_open <= cfg_wdata[0];
				dpf_pkg::RegSignalFloor: cfg_q.signal_floor <= cfg_wdata;
				dpf_pkg::RegMinSpan: cfg_q.min_span <= cfg_wdata;
				dpf_pkg::RegClosedLimit: cfg_q.closed_limit <= cfg_wdata[dpf_pkg::PosW-1:0];
				dpf_pkg::RegMoveTolerance: begin
					cfg_q.move_tolerance <= cfg_wdata[dpf_pkg::PosW-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* rtl/dpf_ctrl.sv */
// Sequencer of the damper position feedback block: handshakes and divide step control.
// Depends on dpf_pkg for the command and status bundles.
`default_nettype none
module dpf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output dpf_pkg::ctrl_cmd_t cmd,
	input wire dpf_pkg::dp_status_t status
);

	typedef enum logic [4:0] {
		StIdle = 5'b00001,
		StMul = 5'b00010,
		StInit = 5'b00100,
		StDiv = 5'b01000,
		StFin = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			StIdle: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = StMul;
				end
			end
			StMul: begin
				cmd.mul = 1'b1;
				state_d = StInit;
			end
			StInit: begin
				cmd.init = 1'b1;
				state_d = StDiv;
			end
			StDiv: begin
				cmd.step = 1'b1;
				if (status.div_last) begin
					state_d = StFin;
				end
			end
			StFin: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/dpf_datapath.sv */
// Datapath of the damper position feedback block: quiet counter, scaling multiply,
// restoring divide by the span, clamp, flags and result registers. Uses dpf_pkg.
`default_nettype none
module dpf_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire dpf_pkg::cfg_t cfg,
	input wire dpf_pkg::ctrl_cmd_t cmd,
	output dpf_pkg::dp_status_t status,
	input wire logic [dpf_pkg::RawW-1:0] raw_sample,
	output logic has_signal,
	output logic position_valid,
	output logic [dpf_pkg::PosW-1:0] position_hundredths,
	output logic is_closed,
	output logic is_moving
);

	localparam int RawW = dpf_pkg::RawW;
	localparam int PosW = dpf_pkg::PosW;
	localparam int ProdW = dpf_pkg::ProdW;

	logic [dpf_pkg::QuietW-1:0] quiet_q;
	logic [dpf_pkg::QuietW-1:0] quiet_d;
	logic [dpf_pkg::StepW-1:0] step_q;

	logic signal_q;
	logic valid_q;
	logic neg_q;
	logic ovf_q;
	logic [RawW-1:0] diff_q;
	logic [ProdW-1:0] prod_q;
	logic [RawW-1:0] rem_q;
	logic [PosW-1:0] qd_q;

	logic [RawW-1:0] span;
	logic span_ok;
	logic [RawW:0] rem_shift;
	logic rem_ge;
	logic [RawW:0] rem_sub;
	logic big;
	logic [PosW-1:0] pos;
	logic [PosW-1:0] target_gap;

	logic has_signal_q;
	logic position_valid_q;
	logic [PosW-1:0] position_q;
	logic is_closed_q;
	logic is_moving_q;

	assign span = cfg.cal_high - cfg.cal_low;
	assign span_ok = (cfg.cal_high > cfg.cal_low) && (span >= cfg.min_span);

	always_comb begin
		quiet_d = quiet_q;
		if (raw_sample < cfg.signal_floor) begin
			if (quiet_q < dpf_pkg::QuietLimit) begin
				quiet_d = quiet_q + 1'b1;
			end
		end else begin
			quiet_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_q <= dpf_pkg::QuietLimit;
			step_q <= '0;
		end else begin
			if (cmd.load) begin
				quiet_q <= quiet_d;
			end
			if (cmd.init) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign status.div_last = (step_q == dpf_pkg::StepW'(dpf_pkg::DivSteps - 1));

	assign rem_shift = {rem_q, qd_q[PosW-1]};
	assign rem_ge = rem_shift >= {1'b0, span};
	assign rem_sub = rem_shift - {1'b0, span};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			signal_q <= quiet_d < dpf_pkg::QuietLimit;
			valid_q <= (quiet_d < dpf_pkg::QuietLimit) && span_ok;
			neg_q <= raw_sample < cfg.cal_low;
			diff_q <= (raw_sample >= cfg.cal_low) ? (raw_sample - cfg.cal_low)
				: (cfg.cal_low - raw_sample);
		end
		if (cmd.mul) begin
			prod_q <= ProdW'(diff_q) * ProdW'(dpf_pkg::FullScale);
		end
		if (cmd.init) begin
			rem_q <= prod_q[ProdW-1:PosW];
			ovf_q <= prod_q[ProdW-1:PosW] >= span;
			qd_q <= prod_q[PosW-1:0];
		end else if (cmd.step) begin
			rem_q <= rem_ge ? rem_sub[RawW-1:0] : rem_shift[RawW-1:0];
			qd_q <= {qd_q[PosW-2:0], rem_ge};
		end
	end

	assign big = ovf_q || (qd_q > dpf_pkg::FullScale);

	always_comb begin
		if (neg_q) begin
			pos = cfg.low_means_open ? dpf_pkg::FullScale : '0;
		end else if (big) begin
			pos = cfg.low_means_open ? '0 : dpf_pkg::FullScale;
		end else begin
			pos = cfg.low_means_open ? (dpf_pkg::FullScale - qd_q) : qd_q;
		end
		target_gap = cfg.target_is_open ? (dpf_pkg::FullScale - pos) : pos;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			has_signal_q <= signal_q;
			position_valid_q <= valid_q;
			position_q <= valid_q ? pos : '0;
			is_closed_q <= valid_q && (pos <= cfg.closed_limit);
			is_moving_q <= valid_q && (target_gap > cfg.move_tolerance);
		end
	end

	assign has_signal = has_signal_q;
	assign position_valid = position_valid_q;
	assign position_hundredths = position_q;
	assign is_closed = is_closed_q;
	assign is_moving = is_moving_q;

endmodule
`default_nettype wire

/* rtl/damper_position_feedback.sv */
// Top level of the damper position feedback block.
// Instantiates dpf_cfg, dpf_ctrl and dpf_datapath; uses dpf_pkg.
//
//   port group     kind          fields
//   in             valid/ready   raw_sample
//   out            valid/ready   has_signal, position_valid, position_hundredths,
//                                is_closed, is_moving
//   cfg            write only    cfg_we, cfg_index, cfg_wdata
//
// After input acceptance come one scaling multiply, one remainder seed and 14 restoring
// divide steps of the shared subtractor, then the result register write. in_ready
// returns the cycle after, so one transaction is done before the next input is taken.
// Reset clears the sequencer and sets the quiet counter to no signal.
// A waiting result stalls the final write, and the next input is not taken meanwhile.
`default_nettype none
module damper_position_feedback (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [dpf_pkg::RawW-1:0] raw_sample,
	output logic out_valid,
	input wire logic out_ready,
	output logic has_signal,
	output logic position_valid,
	output logic [dpf_pkg::PosW-1:0] position_hundredths,
	output logic is_closed,
	output logic is_moving,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [dpf_pkg::RawW-1:0] cfg_wdata
);

	dpf_pkg::cfg_t cfg;
	dpf_pkg::ctrl_cmd_t cmd;
	dpf_pkg::dp_status_t status;

	dpf_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	dpf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.status(status)
	);

	dpf_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.status(status),
		.raw_sample(raw_sample),
		.has_signal(has_signal),
		.position_valid(position_valid),
		.position_hundredths(position_hundredths),
		.is_closed(is_closed),
		.is_moving(is_moving)
	);

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for damper_position_feedback: directed and random raw samples
// over several calibrations, with a built-in predictor of position and flags.
// Depends on rtl/dpf_pkg.sv and rtl/damper_position_feedback.sv.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RawW = dpf_pkg::RawW;
	localparam int PosW = dpf_pkg::PosW;
	localparam int QuietW = dpf_pkg::QuietW;
	localparam int StallLimit = 2000;
	localparam longint Scale = longint'(dpf_pkg::FullScale);

	typedef struct packed {
		logic has_signal;
		logic position_valid;
		logic [PosW-1:0] position;
		logic is_closed;
		logic is_moving;
	} feedback_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [RawW-1:0] raw_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic has_signal;
	logic position_valid;
	logic [PosW-1:0] position_hundredths;
	logic is_closed;
	logic is_moving;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [RawW-1:0] cfg_wdata = '0;

	dpf_pkg::cfg_t cfg_shadow;
	logic [QuietW-1:0] quiet_run;
	logic [RawW-1:0] raw_backlog[$];
	feedback_t expected_feedback[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle_pct = 20;
	int recv_idle_pct = 60;

	damper_position_feedback DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_sample(raw_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.has_signal(has_signal),
		.position_valid(position_valid),
		.position_hundredths(position_hundredths),
		.is_closed(is_closed),
		.is_moving(is_moving),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic feedback_t predict_feedback(logic [RawW-1:0] s);
		feedback_t r;
		longint smp, lo, sp, q, target, gap;
		r = '0;
		if (s < cfg_shadow.signal_floor) begin
			if (quiet_run < dpf_pkg::QuietLimit)
				quiet_run = quiet_run + 1'b1;
		end else begin
			quiet_run = '0;
		end
		r.has_signal = quiet_run < dpf_pkg::QuietLimit;
		if (r.has_signal && cfg_shadow.cal_high > cfg_shadow.cal_low) begin
			smp = s;
			lo = cfg_shadow.cal_low;
			sp = longint'(cfg_shadow.cal_high) - lo;
			if (sp >= longint'(cfg_shadow.min_span)) begin
				q = (smp >= lo) ? ((smp - lo) * Scale) / sp : -(((lo - smp) * Scale) / sp);
				if (cfg_shadow.low_means_open)
					q = Scale - q;
				if (q < 0)
					q = 0;
				if (q > Scale)
					q = Scale;
				target = cfg_shadow.target_is_open ? Scale : 0;
				gap = (q >= target) ? q - target : target - q;
				r.position_valid = 1'b1;
				r.position = q[PosW-1:0];
				r.is_closed = q <= longint'(cfg_shadow.closed_limit);
				r.is_moving = gap > longint'(cfg_shadow.move_tolerance);
			end
		end
		return r;
	endfunction

	function automatic void check_field(string label, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d actual %0d", $time, label, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		if (!arst_n) begin
			in_valid <= 1'b0;
			raw_sample <= '0;
		end else begin
			if (in_valid && in_ready)
				expected_feedback.push_back(predict_feedback(raw_sample));
			if (!in_valid || in_ready) begin
				if (raw_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					in_valid <= 1'b1;
					raw_sample <= raw_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		feedback_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_feedback.size() == 0) begin
					$display("%0t ns: result with no transaction pending", $time);
					errors++;
				end else begin
					want = expected_feedback.pop_front();
					check_field("has_signal", want.has_signal, has_signal);
					check_field("position_valid", want.position_valid, position_valid);
					check_field("position_hundredths", want.position, position_hundredths);
					check_field("is_closed", want.is_closed, is_closed);
					check_field("is_moving", want.is_moving, is_moving);
				end
			end
			out_ready <= $urandom_range(99, 0) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(dpf_pkg::cfg_reg_t idx, logic [RawW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			dpf_pkg::RegCalLow: cfg_shadow.cal_low = value;
			dpf_pkg::RegCalHigh: cfg_shadow.cal_high = value;
			dpf_pkg::RegLowMeansOpen: cfg_shadow.low_means_open = value[0];
			dpf_pkg::RegTargetIsOpen: cfg_shadow.target_is_open = value[0];
			dpf_pkg::RegSignalFloor: cfg_shadow.signal_floor = value;
			dpf_pkg::RegMinSpan: cfg_shadow.min_span = value;
			dpf_pkg::RegClosedLimit: cfg_shadow.closed_limit = value[PosW-1:0];
			dpf_pkg::RegMoveTolerance: cfg_shadow.move_tolerance = value[PosW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(int unsigned lo, int unsigned hi, bit lmo, bit tio,
		int unsigned floor_v, int unsigned span_min, int unsigned closed_v, int unsigned tol_v);
		write_reg(dpf_pkg::RegCalLow, RawW'(lo));
		write_reg(dpf_pkg::RegCalHigh, RawW'(hi));
		write_reg(dpf_pkg::RegLowMeansOpen, RawW'(lmo));
		write_reg(dpf_pkg::RegTargetIsOpen, RawW'(tio));
		write_reg(dpf_pkg::RegSignalFloor, RawW'(floor_v));
		write_reg(dpf_pkg::RegMinSpan, RawW'(span_min));
		write_reg(dpf_pkg::RegClosedLimit, RawW'(closed_v));
		write_reg(dpf_pkg::RegMoveTolerance, RawW'(tol_v));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (raw_backlog.size() != 0 || in_valid || expected_feedback.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned lo_v, hi_v, floor_v, mn, mx, s;
		int count, n, r;
		cfg_shadow.cal_low = '0;
		cfg_shadow.cal_high = '1;
		cfg_shadow.low_means_open = 1'b0;
		cfg_shadow.target_is_open = 1'b0;
		cfg_shadow.signal_floor = RawW'(100);
		cfg_shadow.min_span = RawW'(100);
		cfg_shadow.closed_limit = PosW'(500);
		cfg_shadow.move_tolerance = PosW'(500);
		quiet_run = dpf_pkg::QuietLimit;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset calibration: no signal before the first loud sample, then signal loss
		raw_backlog.push_back(16'd0);
		raw_backlog.push_back(16'd65535);
		raw_backlog.push_back(16'd100);
		repeat (8) raw_backlog.push_back(16'd99);
		raw_backlog.push_back(16'd32768);
		drain();

		// inverted scale, zero floor, samples outside calibration, limits above range
		apply_config(1000, 1100, 1, 1, 0, 100, 16383, 16383);
		raw_backlog.push_back(16'd0);
		raw_backlog.push_back(16'd1050);
		raw_backlog.push_back(16'd1100);
		raw_backlog.push_back(16'd65535);
		drain();

		// descending calibration
		apply_config(5000, 1000, 0, 0, 100, 100, 500, 500);
		raw_backlog.push_back(16'd3000);
		raw_backlog.push_back(16'd65535);
		drain();

		// zero span with zero minimum span
		apply_config(2000, 2000, 0, 1, 100, 0, 500, 500);
		raw_backlog.push_back(16'd2000);
		raw_backlog.push_back(16'd0);
		drain();

		// full span at the largest minimum, highest floor, zero limits
		apply_config(0, 65535, 0, 0, 65535, 65535, 0, 0);
		raw_backlog.push_back(16'd65535);
		raw_backlog.push_back(16'd65534);
		raw_backlog.push_back(16'd0);
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			if (phase < 4) begin
				send_idle_pct = 20;
				recv_idle_pct = 60;
			end else if (phase < 8) begin
				send_idle_pct = 60;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			lo_v = $urandom_range(60000, 0);
			case ($urandom_range(9, 0))
				0: begin
					lo_v = $urandom_range(65535, 0);
					hi_v = $urandom_range(65535, 0);
				end
				1: begin
					lo_v = 0;
					hi_v = 65535;
				end
				default: hi_v = lo_v + $urandom_range(65535 - lo_v, 1);
			endcase
			case ($urandom_range(9, 0))
				0: floor_v = 0;
				1: floor_v = $urandom_range(65535, 0);
				default: floor_v = $urandom_range(2000, 1);
			endcase
			apply_config(lo_v, hi_v, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
				floor_v,
				($urandom_range(9, 0) == 0) ? $urandom_range(65535, 0) : $urandom_range(300, 1),
				($urandom_range(9, 0) == 0) ? $urandom_range(16383, 10001)
					: $urandom_range(10000, 0),
				($urandom_range(9, 0) == 0) ? $urandom_range(16383, 10001)
					: $urandom_range(10000, 0));
			mn = (lo_v < hi_v) ? lo_v : hi_v;
			mx = (lo_v < hi_v) ? hi_v : lo_v;
			count = 0;
			while (count < 60) begin
				r = $urandom_range(99, 0);
				if (r < 60) begin
					raw_backlog.push_back(RawW'($urandom_range(mx, mn)));
					count++;
				end else if (r < 68) begin
					case ($urandom_range(3, 0))
						0: s = lo_v;
						1: s = hi_v;
						2: s = floor_v;
						default: s = floor_v - 1;
					endcase
					raw_backlog.push_back(RawW'(s));
					count++;
				end else if (r < 80) begin
					n = $urandom_range(12, 1);
					repeat (n) begin
						raw_backlog.push_back((floor_v == 0) ? '0
							: RawW'($urandom_range(floor_v - 1, 0)));
						count++;
					end
				end else begin
					raw_backlog.push_back(RawW'($urandom_range(65535, 0)));
					count++;
				end
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && expected_feedback.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
